// File: hdl/ray_carve_log_odds_grid_defines.svh
// Assertion macros used by the occupancy grid checker.
// Needs nothing else; included by the checker file.
`ifndef RAY_CARVE_LOG_ODDS_GRID_DEFINES_SVH
`define RAY_CARVE_LOG_ODDS_GRID_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RCLOG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rclog same-cycle check failed");

// Next-cycle implication, disabled during reset
`define RCLOG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rclog next-cycle check failed");

`endif

// File: hdl/rclog_pkg.sv
// Shared types, constants and helper functions of the log-odds grid.
// Used by every module of the block; depends on nothing.
package rclog_pkg;

    localparam int COORD_W       = 10;
    localparam int CELL_W        = 16;
    localparam int COUNT_W       = 10;
    localparam int ERR_W         = 14;
    localparam int GRID_BITS_DEF = 10;
    localparam int CFG_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic signed [CELL_W-1:0]  cell_t;
    typedef logic [COUNT_W-1:0]        count_t;
    typedef logic [1:0]                op_t;

    localparam op_t OP_TRACE = 2'd0;
    localparam op_t OP_READ  = 2'd1;
    localparam op_t OP_ADD   = 2'd2;

    localparam logic REG_FREE_INC = 1'b0;
    localparam logic REG_OCC_INC  = 1'b1;

    localparam cell_t FREE_INC_RESET = -16'sd1486;
    localparam cell_t OCC_INC_RESET  = 16'sd1486;

    typedef struct packed {
        op_t    op;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        coord_t skip_x;
        coord_t skip_y;
    } item_t;

    typedef struct packed {
        cell_t  cell_value;
        count_t cells_updated;
    } result_t;

    typedef struct packed {
        cell_t free_inc;
        cell_t occ_inc;
    } cfg_t;

    typedef struct packed {
        logic  valid;
        logic  write;
        cell_t inc;
    } grid_ctl_t;

    typedef struct packed {
        logic  valid;
        cell_t value;
    } grid_resp_t;

    typedef struct packed {
        logic clearing;
        logic pending;
    } grid_stat_t;

    typedef struct packed {
        logic busy;
        logic cell_valid;
    } step_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RAY,
        ST_CELL,
        ST_DONE
    } state_t;

    function automatic logic in_grid(coord_t x, coord_t y, int gb);
        logic ok;
        if (gb >= COORD_W)
        begin
            ok = 1'b1;
        end
        else
        begin
            ok = ((x >> gb) == '0) && ((y >> gb) == '0);
        end
        return ok;
    endfunction

    function automatic cell_t sat_add(cell_t a, cell_t b);
        logic signed [CELL_W:0] s;
        cell_t r;
        s = $signed({a[CELL_W-1], a}) + $signed({b[CELL_W-1], b});
        case (s[CELL_W:CELL_W-1])
            2'b01:   r = {1'b0, {(CELL_W-1){1'b1}}};
            2'b10:   r = {1'b1, {(CELL_W-1){1'b0}}};
            default: r = s[CELL_W-1:0];
        endcase
        return r;
    endfunction

endpackage

// File: hdl/rclog_stream_if.sv
// Valid/ready stream channel carrying one word per handshake.
// The word type is set per instance; no other dependencies.
interface rclog_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/ray_carve_log_odds_grid.sv
// Log-odds occupancy grid with Bresenham ray carving (top level).
// Depends on rclog_pkg, rclog_stream_if, rclog_apb_regs, rclog_ray_stepper
// and rclog_grid_mem.
//
// Usage: commands arrive on the cmd stream (valid/ready), one result word
// leaves on the res stream for every command. The APB port holds the free
// and occupied increments (byte addresses 0 and 4).
// Op 0 walks the ray one cell per cycle through the stepper, whose cells
// are read, saturated and written back through the grid memory pipeline.
// A ray's result is loaded once the stepper and the grid memory are idle;
// ops 1 and 2 read or add to the start cell and return its value, while
// op 3 and an op 1 or 2 whose start cell is off the grid return a zero
// result without a grid access.
// One command is in work at a time; a finished result waits in the output
// register while the next command may be accepted.
// Reset: the grid memory is cleared one cell a cycle, all 2^(2*GRID_BITS)
// cells (1048576 at GRID_BITS = 10), while cmd.ready stays low; APB
// writes are taken throughout. When res is stalled, the result holds and a
// further finished result waits until the output register frees.
module ray_carve_log_odds_grid #(
    parameter int GRID_BITS = rclog_pkg::GRID_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rclog_stream_if.sink                        cmd,
    rclog_stream_if.source                      res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rclog_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [rclog_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rclog_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    localparam int ADDR_W = 2 * GRID_BITS;

    rclog_pkg::cfg_t            cfg;
    rclog_pkg::item_t           item;
    rclog_pkg::step_stat_t      step_stat;
    logic [ADDR_W-1:0]          step_addr;
    rclog_pkg::count_t          step_count;
    rclog_pkg::grid_ctl_t       grid_ctl;
    logic [ADDR_W-1:0]          grid_addr;
    rclog_pkg::grid_resp_t      grid_resp;
    rclog_pkg::grid_stat_t      grid_stat;

    rclog_pkg::state_t          state_reg, state_next;
    logic                       cmd_ready;
    logic                       accept;
    logic                       step_start;
    logic                       cell_ok;
    logic                       ray_done;
    logic                       out_load;

    logic                       cell_req_valid_reg, cell_req_valid_next;
    logic                       cell_req_write_reg, cell_req_write_next;
    logic [ADDR_W-1:0]          cell_req_addr_reg, cell_req_addr_next;
    rclog_pkg::cell_t           res_value_reg, res_value_next;
    rclog_pkg::count_t          res_count_reg, res_count_next;
    logic                       out_valid_reg, out_valid_next;
    rclog_pkg::result_t         out_word_reg, out_word_next;

    rclog_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rclog_ray_stepper #(
        .GRID_BITS (GRID_BITS)
    ) u_stepper (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (step_start),
        .item      (item),
        .stat      (step_stat),
        .cell_addr (step_addr),
        .count     (step_count)
    );

    rclog_grid_mem #(
        .GRID_BITS (GRID_BITS)
    ) u_grid (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (grid_ctl),
        .addr  (grid_addr),
        .resp  (grid_resp),
        .stat  (grid_stat)
    );

    assign item     = cmd.payload;
    assign accept   = cmd.valid & cmd_ready;
    assign cell_ok  = rclog_pkg::in_grid(item.start_x, item.start_y, GRID_BITS);
    assign ray_done = !step_stat.busy && !grid_stat.pending;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rclog_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.op)
                        rclog_pkg::OP_TRACE:
                            state_next = rclog_pkg::ST_RAY;
                        rclog_pkg::OP_READ, rclog_pkg::OP_ADD:
                            state_next = cell_ok ? rclog_pkg::ST_CELL : rclog_pkg::ST_DONE;
                        default:
                            state_next = rclog_pkg::ST_DONE;
                    endcase
                end
            end
            rclog_pkg::ST_RAY:
            begin
                if (ray_done)
                begin
                    state_next = rclog_pkg::ST_DONE;
                end
            end
            rclog_pkg::ST_CELL:
            begin
                if (grid_resp.valid)
                begin
                    state_next = rclog_pkg::ST_DONE;
                end
            end
            rclog_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = rclog_pkg::ST_IDLE;
                end
            end
            default:
                state_next = rclog_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        cmd_ready  = (state_reg == rclog_pkg::ST_IDLE) && !grid_stat.clearing;
        step_start = accept && (item.op == rclog_pkg::OP_TRACE);
        out_load   = (state_reg == rclog_pkg::ST_DONE) && (!out_valid_reg || res.ready);
        if (state_reg == rclog_pkg::ST_RAY)
        begin
            grid_ctl.valid = step_stat.cell_valid;
            grid_ctl.write = 1'b1;
            grid_ctl.inc   = cfg.free_inc;
            grid_addr      = step_addr;
        end
        else
        begin
            grid_ctl.valid = cell_req_valid_reg;
            grid_ctl.write = cell_req_write_reg;
            grid_ctl.inc   = cfg.occ_inc;
            grid_addr      = cell_req_addr_reg;
        end
    end

    assign cmd.ready = cmd_ready;

    always_comb
    begin
        cell_req_valid_next = accept && cell_ok
                              && (item.op == rclog_pkg::OP_READ || item.op == rclog_pkg::OP_ADD);
        cell_req_write_next = (item.op == rclog_pkg::OP_ADD);
        cell_req_addr_next  = (ADDR_W'(item.start_y) << GRID_BITS) | ADDR_W'(item.start_x);
        res_value_next      = res_value_reg;
        res_count_next      = res_count_reg;
        if (accept)
        begin
            res_value_next = '0;
            res_count_next = '0;
        end
        else if (state_reg == rclog_pkg::ST_RAY && ray_done)
        begin
            res_value_next = '0;
            res_count_next = step_count;
        end
        else if (state_reg == rclog_pkg::ST_CELL && grid_resp.valid)
        begin
            res_value_next = grid_resp.value;
            res_count_next = '0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_word_next  = {res_value_reg, res_count_reg};
        end
        else
        begin
            out_valid_next = out_valid_reg && !res.ready;
            out_word_next  = out_word_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= rclog_pkg::ST_IDLE;
            cell_req_valid_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            cell_req_valid_reg <= cell_req_valid_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_req_write_reg <= cell_req_write_next;
        cell_req_addr_reg  <= cell_req_addr_next;
        res_value_reg      <= res_value_next;
        res_count_reg      <= res_count_next;
        out_word_reg       <= out_word_next;
    end

    assign res.valid   = out_valid_reg;
    assign res.payload = out_word_reg;

endmodule

// File: hdl/rclog_apb_regs.sv
// APB configuration registers: free and occupied log-odds increments.
// Depends on rclog_pkg.
module rclog_apb_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rclog_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [rclog_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rclog_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output rclog_pkg::cfg_t                     cfg
);
    localparam int EXT_W = rclog_pkg::APB_DATA_W - rclog_pkg::CELL_W;

    logic             reg_sel;
    logic             wr_en;
    rclog_pkg::cell_t free_inc_reg;
    rclog_pkg::cell_t free_inc_next;
    rclog_pkg::cell_t occ_inc_reg;
    rclog_pkg::cell_t occ_inc_next;

    assign pready  = 1'b1;
    assign reg_sel = paddr[rclog_pkg::CFG_ADDR_W-1];
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb
    begin
        free_inc_next = free_inc_reg;
        occ_inc_next  = occ_inc_reg;
        if (wr_en)
        begin
            case (reg_sel)
                rclog_pkg::REG_FREE_INC: free_inc_next = pwdata[rclog_pkg::CELL_W-1:0];
                rclog_pkg::REG_OCC_INC:  occ_inc_next  = pwdata[rclog_pkg::CELL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_inc_reg <= rclog_pkg::FREE_INC_RESET;
            occ_inc_reg  <= rclog_pkg::OCC_INC_RESET;
        end
        else
        begin
            free_inc_reg <= free_inc_next;
            occ_inc_reg  <= occ_inc_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            rclog_pkg::REG_FREE_INC:
                prdata = {{EXT_W{free_inc_reg[rclog_pkg::CELL_W-1]}}, free_inc_reg};
            rclog_pkg::REG_OCC_INC:
                prdata = {{EXT_W{occ_inc_reg[rclog_pkg::CELL_W-1]}}, occ_inc_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.free_inc = free_inc_reg;
    assign cfg.occ_inc  = occ_inc_reg;

endmodule

// File: hdl/rclog_ray_stepper.sv
// Bresenham ray stepper: one cell address per cycle along the major axis.
// Depends on rclog_pkg; feeds cell writes to the grid memory.
module rclog_ray_stepper #(
    parameter int GRID_BITS = rclog_pkg::GRID_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  rclog_pkg::item_t            item,
    output rclog_pkg::step_stat_t       stat,
    output logic [2*GRID_BITS-1:0]      cell_addr,
    output rclog_pkg::count_t           count
);
    localparam int ADDR_W  = 2 * GRID_BITS;
    localparam int COORD_W = rclog_pkg::COORD_W;
    localparam int ERR_W   = rclog_pkg::ERR_W;

    // start decode
    logic signed [COORD_W:0]     dx;
    logic signed [COORD_W:0]     dy;
    rclog_pkg::coord_t           adx;
    rclog_pkg::coord_t           ady;
    logic                        x_major_s;
    rclog_pkg::coord_t           d_maj_s;
    rclog_pkg::coord_t           d_min_s;
    logic signed [ERR_W-1:0]     err_init;

    // step datapath
    rclog_pkg::coord_t           maj_nx;
    rclog_pkg::coord_t           min_nx;
    logic                        stop;
    logic signed [ERR_W-1:0]     err_a;
    logic signed [ERR_W-1:0]     err_n;
    logic                        step_min;
    rclog_pkg::coord_t           cx;
    rclog_pkg::coord_t           cy;
    logic                        cell_write;

    // registers
    logic                        running_reg, running_next;
    logic                        cell_valid_reg, cell_valid_next;
    rclog_pkg::count_t           count_reg, count_next;
    logic                        x_major_reg, x_major_next;
    logic                        maj_neg_reg, maj_neg_next;
    logic                        min_neg_reg, min_neg_next;
    rclog_pkg::coord_t           maj_reg, maj_next;
    rclog_pkg::coord_t           min_reg, min_next;
    rclog_pkg::coord_t           maj_end_reg, maj_end_next;
    rclog_pkg::coord_t           d_maj_reg, d_maj_next;
    rclog_pkg::coord_t           d_min_reg, d_min_next;
    logic signed [ERR_W-1:0]     err_reg, err_next;
    rclog_pkg::coord_t           skip_x_reg, skip_x_next;
    rclog_pkg::coord_t           skip_y_reg, skip_y_next;
    logic [ADDR_W-1:0]           addr_reg, addr_next;

    always_comb
    begin
        dx  = $signed({1'b0, item.end_x}) - $signed({1'b0, item.start_x});
        dy  = $signed({1'b0, item.end_y}) - $signed({1'b0, item.start_y});
        adx = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
        ady = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
        x_major_s = adx > ady;
        d_maj_s   = x_major_s ? adx : ady;
        d_min_s   = x_major_s ? ady : adx;
        err_init  = $signed(ERR_W'({d_min_s, 1'b0})) - $signed(ERR_W'(d_maj_s));
    end

    always_comb
    begin
        maj_nx   = maj_neg_reg ? maj_reg - 1'b1 : maj_reg + 1'b1;
        stop     = (maj_nx == maj_end_reg);
        err_a    = err_reg + $signed(ERR_W'({d_min_reg, 1'b0}));
        step_min = !err_a[ERR_W-1];
        err_n    = step_min ? err_a - $signed(ERR_W'({d_maj_reg, 1'b0})) : err_a;
        if (step_min)
        begin
            min_nx = min_neg_reg ? min_reg - 1'b1 : min_reg + 1'b1;
        end
        else
        begin
            min_nx = min_reg;
        end
        cx = x_major_reg ? maj_nx : min_nx;
        cy = x_major_reg ? min_nx : maj_nx;
        cell_write = !(cx == skip_x_reg && cy == skip_y_reg)
                     && rclog_pkg::in_grid(cx, cy, GRID_BITS);
    end

    always_comb
    begin
        running_next    = running_reg;
        cell_valid_next = 1'b0;
        count_next      = count_reg;
        x_major_next    = x_major_reg;
        maj_neg_next    = maj_neg_reg;
        min_neg_next    = min_neg_reg;
        maj_next        = maj_reg;
        min_next        = min_reg;
        maj_end_next    = maj_end_reg;
        d_maj_next      = d_maj_reg;
        d_min_next      = d_min_reg;
        err_next        = err_reg;
        skip_x_next     = skip_x_reg;
        skip_y_next     = skip_y_reg;
        addr_next       = addr_reg;
        if (start)
        begin
            running_next = (adx != '0) || (ady != '0);
            count_next   = '0;
            x_major_next = x_major_s;
            maj_neg_next = x_major_s ? dx[COORD_W] : dy[COORD_W];
            min_neg_next = x_major_s ? dy[COORD_W] : dx[COORD_W];
            maj_next     = x_major_s ? item.start_x : item.start_y;
            min_next     = x_major_s ? item.start_y : item.start_x;
            maj_end_next = x_major_s ? item.end_x : item.end_y;
            d_maj_next   = d_maj_s;
            d_min_next   = d_min_s;
            err_next     = err_init;
            skip_x_next  = item.skip_x;
            skip_y_next  = item.skip_y;
        end
        else if (running_reg)
        begin
            if (stop)
            begin
                running_next = 1'b0;
            end
            else
            begin
                maj_next        = maj_nx;
                min_next        = min_nx;
                err_next        = err_n;
                cell_valid_next = cell_write;
                addr_next       = (ADDR_W'(cy) << GRID_BITS) | ADDR_W'(cx);
                if (cell_write)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            cell_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            running_reg    <= running_next;
            cell_valid_reg <= cell_valid_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_major_reg <= x_major_next;
        maj_neg_reg <= maj_neg_next;
        min_neg_reg <= min_neg_next;
        maj_reg     <= maj_next;
        min_reg     <= min_next;
        maj_end_reg <= maj_end_next;
        d_maj_reg   <= d_maj_next;
        d_min_reg   <= d_min_next;
        err_reg     <= err_next;
        skip_x_reg  <= skip_x_next;
        skip_y_reg  <= skip_y_next;
        addr_reg    <= addr_next;
    end

    assign stat.busy       = running_reg | cell_valid_reg;
    assign stat.cell_valid = cell_valid_reg;
    assign cell_addr       = addr_reg;
    assign count           = count_reg;

endmodule

// File: hdl/rclog_grid_mem.sv
// Log-odds grid memory with read-modify-write saturating update.
// Depends on rclog_pkg; clears itself after reset, one cell a cycle.
module rclog_grid_mem #(
    parameter int GRID_BITS = rclog_pkg::GRID_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rclog_pkg::grid_ctl_t        ctl,
    input  logic [2*GRID_BITS-1:0]      addr,
    output rclog_pkg::grid_resp_t       resp,
    output rclog_pkg::grid_stat_t       stat
);
    localparam int ADDR_W = 2 * GRID_BITS;
    localparam int DEPTH  = 1 << ADDR_W;

    rclog_pkg::cell_t     mem [DEPTH];

    logic                 clearing_reg, clearing_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic                 s1_valid_reg;
    logic                 s1_write_reg;
    rclog_pkg::cell_t     s1_inc_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    rclog_pkg::cell_t     rd_data_reg;
    rclog_pkg::cell_t     sum;

    always_comb
    begin
        clearing_next = clearing_reg && (clr_addr_reg != '1);
        clr_addr_next = clearing_reg ? clr_addr_reg + 1'b1 : clr_addr_reg;
        sum           = rclog_pkg::sat_add(rd_data_reg, s1_inc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            s1_valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_write_reg <= ctl.write;
        s1_inc_reg   <= ctl.inc;
        s1_addr_reg  <= addr;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (s1_valid_reg && s1_write_reg)
        begin
            mem[s1_addr_reg] <= sum;
        end
    end

    assign resp.valid    = s1_valid_reg;
    assign resp.value    = s1_write_reg ? sum : rd_data_reg;
    assign stat.clearing = clearing_reg;
    assign stat.pending  = s1_valid_reg;

endmodule

// File: hdl/rclog_checker.sv
// Port-level checks of the log-odds grid, bound to the top level.
// Depends on rclog_pkg and ray_carve_log_odds_grid_defines.svh.
`include "ray_carve_log_odds_grid_defines.svh"

module rclog_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cmd_valid,
    input logic                 cmd_ready,
    input logic                 res_valid,
    input logic                 res_ready,
    input rclog_pkg::result_t   res_word
);

    `RCLOG_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_word))

    `RCLOG_ASSERT_SAME(a_res_exclusive, clk, rst_n, res_valid, res_word.cells_updated == '0 || res_word.cell_value == '0)

    `RCLOG_ASSERT_NEXT(a_one_in_work, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

endmodule

bind ray_carve_log_odds_grid rclog_checker u_rclog_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_word  (res.payload)
);
